>>> rtl/imubc_pkg.sv
package imubc_pkg;

  localparam int NAXES = 6;
  localparam int RAW_W = 16;
  localparam int OUT_W = 21;
  localparam int BIAS_W = 18;
  localparam int DIFF_W = BIAS_W + 1;
  localparam int SUM_W = 26;
  localparam int IDX_W = 11;
  localparam int RANGE_W = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  // reciprocal precision for the divide by the average count
  localparam int RECIP_SHIFT = 26;

  localparam int SKIP_SAMPLES_DEF = 101;
  localparam int AVERAGE_SAMPLES_DEF = 1000;

  // one g at the 2g scale, in counts
  localparam logic [BIAS_W-1:0] ONE_G = BIAS_W'(16384);

  // axis numbering inside the block
  localparam int AXIS_ACC_Z = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACCEL_RANGE    = 3'd0,
    REG_GYRO_RANGE     = 3'd1,
    REG_ACCEL_OFFSET_X = 3'd2,
    REG_ACCEL_OFFSET_Y = 3'd3,
    REG_ACCEL_OFFSET_Z = 3'd4,
    REG_GYRO_OFFSET_X  = 3'd5,
    REG_GYRO_OFFSET_Y  = 3'd6,
    REG_GYRO_OFFSET_Z  = 3'd7
  } reg_index_t;

endpackage

>>> rtl/imubc_if.sv
interface imubc_in_if;
  logic valid;
  logic ready;
  logic signed [imubc_pkg::RAW_W-1:0] acc_x;
  logic signed [imubc_pkg::RAW_W-1:0] acc_y;
  logic signed [imubc_pkg::RAW_W-1:0] acc_z;
  logic signed [imubc_pkg::RAW_W-1:0] rate_x;
  logic signed [imubc_pkg::RAW_W-1:0] rate_y;
  logic signed [imubc_pkg::RAW_W-1:0] rate_z;
  logic start_cal;

  modport source (
    output valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, start_cal,
    input  ready
  );
  modport sink (
    input  valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, start_cal,
    output ready
  );
endinterface

interface imubc_out_if;
  logic valid;
  logic ready;
  logic signed [imubc_pkg::OUT_W-1:0] out_acc_x;
  logic signed [imubc_pkg::OUT_W-1:0] out_acc_y;
  logic signed [imubc_pkg::OUT_W-1:0] out_acc_z;
  logic signed [imubc_pkg::OUT_W-1:0] out_rate_x;
  logic signed [imubc_pkg::OUT_W-1:0] out_rate_y;
  logic signed [imubc_pkg::OUT_W-1:0] out_rate_z;
  logic cal_busy;
  logic cal_done;

  modport source (
    output valid, out_acc_x, out_acc_y, out_acc_z, out_rate_x, out_rate_y, out_rate_z,
           cal_busy, cal_done,
    input  ready
  );
  modport sink (
    input  valid, out_acc_x, out_acc_y, out_acc_z, out_rate_x, out_rate_y, out_rate_z,
           cal_busy, cal_done,
    output ready
  );
endinterface

>>> rtl/imubc_div.sv
module imubc_div #(
  parameter int AVERAGE_SAMPLES = imubc_pkg::AVERAGE_SAMPLES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [imubc_pkg::SUM_W-1:0] sums [imubc_pkg::NAXES],
  output logic done,
  output logic signed [imubc_pkg::RAW_W-1:0] quo [imubc_pkg::NAXES]
);

  localparam int NA = imubc_pkg::NAXES;
  localparam int SW = imubc_pkg::SUM_W;
  localparam int RS = imubc_pkg::RECIP_SHIFT;
  localparam int RW = RS + 1;
  localparam int PW = SW + RW;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << RS) / AVERAGE_SAMPLES);
  localparam logic [SW-1:0] DIVISOR = SW'(AVERAGE_SAMPLES);

  logic v1, v2, v3;
  logic [SW-1:0] mag1 [NA];
  logic [SW-1:0] mag2 [NA];
  logic [PW-1:0] prod2 [NA];
  logic [SW-1:0] q3 [NA];
  logic neg1 [NA];
  logic neg2 [NA];
  logic neg3 [NA];

  logic [SW-1:0] q_est [NA];
  logic [SW-1:0] rem [NA];
  logic [SW-1:0] q_fix [NA];

  // estimate is exact or one low, a single compare fixes it
  always_comb begin
    for (int k = 0; k < NA; k++) begin
      q_est[k] = prod2[k][RS +: SW];
      rem[k] = mag2[k] - q_est[k] * DIVISOR;
      q_fix[k] = q_est[k] + SW'(rem[k] >= DIVISOR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      done <= v3;
    end
    for (int k = 0; k < NA; k++) begin
      neg1[k] <= sums[k][SW-1];
      mag1[k] <= sums[k][SW-1] ? $unsigned(-sums[k]) : $unsigned(sums[k]);
      neg2[k] <= neg1[k];
      mag2[k] <= mag1[k];
      prod2[k] <= PW'(mag1[k]) * PW'(RECIP);
      neg3[k] <= neg2[k];
      q3[k] <= q_fix[k];
      quo[k] <= neg3[k] ? $signed(imubc_pkg::RAW_W'(-q3[k])) : $signed(imubc_pkg::RAW_W'(q3[k]));
    end
  end

endmodule

>>> rtl/imu_bias_calibrate_and_scale_core.sv
// channel  dir  handshake      payload
// smp      in   valid/ready    acc_x..rate_z (16b signed each), start_cal
// res      out  valid/ready    out_acc_x..out_rate_z (21b signed each), cal_busy, cal_done
// cfg      in   cfg_we only    cfg_index (3b), cfg_data (16b)
//
// one sample per cycle: correction and scaling sit between the input handshake and the
// result register; a transaction is taken every cycle while res drains and div_busy is low
// the transaction that completes calibration starts a four-stage reciprocal divide;
// smp.ready stays low until the learned biases are written
// rst is synchronous and clears registers, offsets, learned biases and calibration
// a stalled res holds its result and stops smp, nothing is dropped
module imu_bias_calibrate_and_scale_core #(
  parameter int SKIP_SAMPLES    = imubc_pkg::SKIP_SAMPLES_DEF,
  parameter int AVERAGE_SAMPLES = imubc_pkg::AVERAGE_SAMPLES_DEF
) (
  input  logic clk,
  input  logic rst,
  imubc_in_if.sink   smp,
  imubc_out_if.source res,
  input  logic cfg_we,
  input  logic [imubc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [imubc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NA = imubc_pkg::NAXES;
  localparam int RAW_W = imubc_pkg::RAW_W;
  localparam int OUT_W = imubc_pkg::OUT_W;
  localparam int BIAS_W = imubc_pkg::BIAS_W;
  localparam int DIFF_W = imubc_pkg::DIFF_W;
  localparam int SUM_W = imubc_pkg::SUM_W;
  localparam int IDX_W = imubc_pkg::IDX_W;
  localparam int RANGE_W = imubc_pkg::RANGE_W;
  localparam logic [IDX_W-1:0] FIRST_SUM = IDX_W'(SKIP_SAMPLES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SKIP_SAMPLES + AVERAGE_SAMPLES - 1);

  // configuration registers
  logic [RANGE_W-1:0] accel_range;
  logic [RANGE_W-1:0] gyro_range;
  logic signed [RAW_W-1:0] offsets [NA];

  // calibration state
  logic collecting;
  logic [IDX_W-1:0] sample_index;
  logic signed [SUM_W-1:0] axis_sums [NA];
  logic signed [BIAS_W-1:0] learned_bias [NA];
  logic learned_valid;

  // divide in flight, and whether an offset write has overruled it
  logic div_busy;
  logic div_cancel;
  logic div_start;
  logic div_done;
  logic [RANGE_W-1:0] cal_range;
  logic signed [RAW_W-1:0] quo [NA];

  logic accept;
  logic offset_write;

  logic signed [RAW_W-1:0] raw [NA];
  logic signed [OUT_W-1:0] corr [NA];
  logic signed [SUM_W-1:0] sums_next [NA];
  logic collect_now;
  logic [IDX_W-1:0] idx_now;
  logic last_sample;
  logic busy_next;
  logic done_next;

  assign smp.ready = !div_busy && (!res.valid || res.ready);
  assign accept = smp.valid && smp.ready;
  assign offset_write = cfg_we && (cfg_index != imubc_pkg::REG_ACCEL_RANGE)
                        && (cfg_index != imubc_pkg::REG_GYRO_RANGE);

  always_comb begin
    raw[0] = smp.acc_x;
    raw[1] = smp.acc_y;
    raw[2] = smp.acc_z;
    raw[3] = smp.rate_x;
    raw[4] = smp.rate_y;
    raw[5] = smp.rate_z;
  end

  // correction uses the bias active before this sample
  always_comb begin
    for (int k = 0; k < NA; k++) begin
      logic signed [BIAS_W-1:0] bias;
      logic signed [DIFF_W-1:0] diff;
      logic [RANGE_W-1:0] rng;
      bias = learned_valid ? learned_bias[k] : BIAS_W'(offsets[k]);
      diff = DIFF_W'(raw[k]) - DIFF_W'(bias);
      rng = (k < NA / 2) ? accel_range : gyro_range;
      corr[k] = OUT_W'(diff) <<< rng;
    end
  end

  // start_cal restarts the run with this sample as index zero
  always_comb begin
    collect_now = smp.start_cal || collecting;
    idx_now = smp.start_cal ? '0 : sample_index;
    last_sample = collect_now && (idx_now >= LAST_IDX);
    busy_next = collect_now && !last_sample;
    done_next = last_sample;
    for (int k = 0; k < NA; k++) begin
      logic signed [SUM_W-1:0] base;
      base = smp.start_cal ? '0 : axis_sums[k];
      sums_next[k] = (collect_now && idx_now >= FIRST_SUM) ? base + SUM_W'(raw[k]) : base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_range <= '0;
      gyro_range <= '0;
      for (int k = 0; k < NA; k++) begin
        offsets[k] <= '0;
        axis_sums[k] <= '0;
        learned_bias[k] <= '0;
      end
      collecting <= 1'b0;
      sample_index <= '0;
      learned_valid <= 1'b0;
      div_busy <= 1'b0;
      div_cancel <= 1'b0;
      div_start <= 1'b0;
      cal_range <= '0;
      res.valid <= 1'b0;
    end else begin
      div_start <= accept && last_sample;

      if (accept) begin
        res.valid <= 1'b1;
        collecting <= busy_next;
        if (busy_next) begin
          sample_index <= idx_now + IDX_W'(1);
        end
        for (int k = 0; k < NA; k++) begin
          axis_sums[k] <= sums_next[k];
        end
        if (last_sample) begin
          div_busy <= 1'b1;
          div_cancel <= 1'b0;
          cal_range <= accel_range;
        end
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end

      // learned biases land once the divide drains
      if (div_done) begin
        div_busy <= 1'b0;
        for (int k = 0; k < NA; k++) begin
          if (k == imubc_pkg::AXIS_ACC_Z) begin
            learned_bias[k] <= BIAS_W'(quo[k]) - $signed(imubc_pkg::ONE_G >> cal_range);
          end else begin
            learned_bias[k] <= BIAS_W'(quo[k]);
          end
        end
        if (!div_cancel) begin
          learned_valid <= 1'b1;
        end
      end

      // any offset write falls back to the configured biases
      if (cfg_we) begin
        case (cfg_index)
          imubc_pkg::REG_ACCEL_RANGE: accel_range <= cfg_data[RANGE_W-1:0];
          imubc_pkg::REG_GYRO_RANGE:  gyro_range <= cfg_data[RANGE_W-1:0];
          imubc_pkg::REG_ACCEL_OFFSET_X: offsets[0] <= cfg_data;
          imubc_pkg::REG_ACCEL_OFFSET_Y: offsets[1] <= cfg_data;
          imubc_pkg::REG_ACCEL_OFFSET_Z: offsets[2] <= cfg_data;
          imubc_pkg::REG_GYRO_OFFSET_X:  offsets[3] <= cfg_data;
          imubc_pkg::REG_GYRO_OFFSET_Y:  offsets[4] <= cfg_data;
          imubc_pkg::REG_GYRO_OFFSET_Z:  offsets[5] <= cfg_data;
          default: ;
        endcase
      end
      if (offset_write) begin
        learned_valid <= 1'b0;
        if (div_busy) begin
          div_cancel <= 1'b1;
        end
      end
    end
  end

  // result register, loaded on every accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      res.out_acc_x <= corr[0];
      res.out_acc_y <= corr[1];
      res.out_acc_z <= corr[2];
      res.out_rate_x <= corr[3];
      res.out_rate_y <= corr[4];
      res.out_rate_z <= corr[5];
      res.cal_busy <= busy_next;
      res.cal_done <= done_next;
    end
  end

  imubc_div #(
    .AVERAGE_SAMPLES(AVERAGE_SAMPLES)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sums  (axis_sums),
    .done  (div_done),
    .quo   (quo)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int NAXES = imubc_pkg::NAXES;
  localparam int RAW_W = imubc_pkg::RAW_W;
  localparam int OUT_W = imubc_pkg::OUT_W;
  localparam int BIAS_W = imubc_pkg::BIAS_W;
  localparam int SUM_W = imubc_pkg::SUM_W;
  localparam int IDX_W = imubc_pkg::IDX_W;
  localparam int RANGE_W = imubc_pkg::RANGE_W;
  localparam int CFG_INDEX_W = imubc_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W = imubc_pkg::CFG_DATA_W;

  // calibration lengths, kept at the block's defaults
  localparam int SKIP_N = imubc_pkg::SKIP_SAMPLES_DEF;
  localparam int AVG_N = imubc_pkg::AVERAGE_SAMPLES_DEF;

  // watchdog, far above the slowest legal run of roughly 1400 transactions
  localparam int CYCLE_LIMIT = 500000;

  // long receiver hold-off, so that the result side backs up into smp.ready
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 120;

  // settling time after a drain: covers the reciprocal divide that follows
  // the completing transaction
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [0:NAXES-1][RAW_W-1:0] raw;
    logic start_cal;
  } sample_t;

  typedef struct packed {
    logic [0:NAXES-1][OUT_W-1:0] val;
    logic cal_busy;
    logic cal_done;
  } result_t;

  // one row of the directed table; want is only used where typed is set
  typedef struct packed {
    sample_t stim;
    logic typed;
    result_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 10;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  imubc_in_if smp ();
  imubc_out_if res ();

  imu_bias_calibrate_and_scale_core #(
    .SKIP_SAMPLES(SKIP_N),
    .AVERAGE_SAMPLES(AVG_N)
  ) uut (
    .clk(clk),
    .rst(rst),
    .smp(smp),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor state: a private copy of the registers and the calibration
  // ---------------------------------------------------------------------
  logic [RANGE_W-1:0] acc_rng = '0;
  logic [RANGE_W-1:0] gyr_rng = '0;
  logic signed [RAW_W-1:0] cfg_bias [NAXES] = '{default: '0};
  logic collecting = 1'b0;
  logic [IDX_W-1:0] sample_no = '0;
  logic signed [SUM_W-1:0] axis_sum [NAXES] = '{default: '0};
  logic signed [BIAS_W-1:0] learned [NAXES] = '{default: '0};
  logic learned_ok = 1'b0;

  result_t pending_results [$];
  int n_sent = 0;
  int n_got = 0;
  int n_err = 0;
  int n_cycles = 0;
  bit src_calm = 1'b0;

  // centre and spread of the samples in a calibration run
  int run_centre [NAXES];
  int run_spread;

  string out_name [NAXES] = '{"out_acc_x", "out_acc_y", "out_acc_z",
                              "out_rate_x", "out_rate_y", "out_rate_z"};

  dir_row_t dir_tab [DIR_ROWS];

  // corrects one sample with the bias active before it, then advances the
  // calibration; the completing sample still sees the old bias
  function automatic result_t correct_and_learn(sample_t s);
    result_t r;
    longint d;
    logic signed [BIAS_W-1:0] bias;
    logic [RANGE_W-1:0] rng;
    if (s.start_cal) begin
      // restart: sums and index cleared, earlier learned biases kept
      collecting = 1'b1;
      sample_no = '0;
      for (int k = 0; k < NAXES; k++) axis_sum[k] = '0;
    end
    for (int k = 0; k < NAXES; k++) begin
      bias = learned_ok ? learned[k] : BIAS_W'(cfg_bias[k]);
      rng = (k < 3) ? acc_rng : gyr_rng;
      d = (longint'($signed(s.raw[k])) - longint'(bias)) * (longint'(1) << rng);
      r.val[k] = d[OUT_W-1:0];
    end
    r.cal_busy = 1'b0;
    r.cal_done = 1'b0;
    if (collecting) begin
      if (sample_no >= SKIP_N) begin
        for (int k = 0; k < NAXES; k++)
          axis_sum[k] = axis_sum[k] + SUM_W'($signed(s.raw[k]));
      end
      if (sample_no >= SKIP_N + AVG_N - 1) begin
        // divide truncates toward zero; accel z also loses one g at the
        // range in force right now
        for (int k = 0; k < NAXES; k++)
          learned[k] = BIAS_W'(longint'(axis_sum[k]) / longint'(AVG_N));
        learned[imubc_pkg::AXIS_ACC_Z] = learned[imubc_pkg::AXIS_ACC_Z]
                                         - (imubc_pkg::ONE_G >> acc_rng);
        learned_ok = 1'b1;
        collecting = 1'b0;
        r.cal_done = 1'b1;
      end else begin
        sample_no = sample_no + 1'b1;
        r.cal_busy = 1'b1;
      end
    end
    return r;
  endfunction

  // fully random sample, extremes mixed in, start only where allowed
  function automatic sample_t noise_sample(bit allow_start);
    sample_t s;
    for (int k = 0; k < NAXES; k++) begin
      case ($urandom_range(0, 15))
        0: s.raw[k] = 16'h7fff;
        1: s.raw[k] = 16'h8000;
        2: s.raw[k] = 16'h0000;
        3: s.raw[k] = 16'hffff;
        default: s.raw[k] = 16'($urandom);
      endcase
    end
    s.start_cal = allow_start && ($urandom_range(0, 11) == 0);
    return s;
  endfunction

  // sample of a still sensor: centre plus noise, with the odd wild value
  function automatic sample_t near_sample(bit start);
    sample_t s;
    int jitter;
    for (int k = 0; k < NAXES; k++) begin
      jitter = int'($urandom_range(0, 2 * run_spread)) - run_spread;
      if ($urandom_range(0, 63) == 0) s.raw[k] = 16'($urandom);
      else s.raw[k] = 16'(run_centre[k] + jitter);
    end
    s.start_cal = start;
    return s;
  endfunction

  // offers one transaction, waits for it to be taken, records the expectation
  task automatic put_sample(sample_t s, bit typed, result_t want);
    int gap;
    result_t predicted;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.acc_x <= s.raw[0];
    smp.acc_y <= s.raw[1];
    smp.acc_z <= s.raw[2];
    smp.rate_x <= s.raw[3];
    smp.rate_y <= s.raw[4];
    smp.rate_z <= s.raw[5];
    smp.start_cal <= s.start_cal;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    // the predictor runs on every row so its state stays in step
    predicted = correct_and_learn(s);
    pending_results.push_back(typed ? want : predicted);
    n_sent++;
  endtask

  // drops valid, waits for every result, then lets the divide finish
  task automatic settle();
    smp.valid <= 1'b0;
    while (n_got < n_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the enable is left high for back-to-back writes
  task automatic cfg_write(imubc_pkg::reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      imubc_pkg::REG_ACCEL_RANGE: acc_rng = val[RANGE_W-1:0];
      imubc_pkg::REG_GYRO_RANGE: gyr_rng = val[RANGE_W-1:0];
      default: begin
        // any offset write hands control back to the configured biases
        cfg_bias[idx - imubc_pkg::REG_ACCEL_OFFSET_X] = val;
        learned_ok = 1'b0;
      end
    endcase
  endtask

  task automatic run_noise(int n, bit allow_start);
    for (int i = 0; i < n; i++) put_sample(noise_sample(allow_start), 1'b0, '0);
  endtask

  // compares one result transaction with the oldest expectation
  task automatic check_result();
    result_t got;
    result_t want;
    got.val[0] = res.out_acc_x;
    got.val[1] = res.out_acc_y;
    got.val[2] = res.out_acc_z;
    got.val[3] = res.out_rate_x;
    got.val[4] = res.out_rate_y;
    got.val[5] = res.out_rate_z;
    got.cal_busy = res.cal_busy;
    got.cal_done = res.cal_done;
    n_got++;
    if (pending_results.size() == 0) begin
      $error("result transaction with nothing expected");
      n_err++;
    end else begin
      want = pending_results.pop_front();
      for (int k = 0; k < NAXES; k++) begin
        if (got.val[k] !== want.val[k]) begin
          $error("%s: expected %0d, got %0d", out_name[k],
                 $signed(want.val[k]), $signed(got.val[k]));
          n_err++;
        end
      end
      if (got.cal_busy !== want.cal_busy) begin
        $error("cal_busy: expected %0d, got %0d", want.cal_busy, got.cal_busy);
        n_err++;
      end
      if (got.cal_done !== want.cal_done) begin
        $error("cal_done: expected %0d, got %0d", want.cal_done, got.cal_done);
        n_err++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // result side: random stalls, quiet stretches and one long hold-off
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    bit calm;
    calm = 1'b0;
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 18);
      // hold the result side long enough that the block stops taking samples
      if (n_got == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      check_result();
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int restart_at;
    int n_run;

    // after reset: no bias, range 0, so results are the raw counts widened
    dir_tab = '{
      '{'{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0}, 1'b1,
        '{'{21'h000000, 21'h000000, 21'h000000, 21'h000000, 21'h000000, 21'h000000},
          1'b0, 1'b0}},
      '{'{'{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0}, 1'b1,
        '{'{21'h007fff, 21'h007fff, 21'h007fff, 21'h007fff, 21'h007fff, 21'h007fff},
          1'b0, 1'b0}},
      '{'{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0}, 1'b1,
        '{'{21'h1f8000, 21'h1f8000, 21'h1f8000, 21'h1f8000, 21'h1f8000, 21'h1f8000},
          1'b0, 1'b0}},
      '{'{'{16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h5555, 16'haaaa}, 1'b0}, 1'b1,
        '{'{21'h007fff, 21'h1f8000, 21'h000001, 21'h1fffff, 21'h005555, 21'h1faaaa},
          1'b0, 1'b0}},
      '{'{'{16'hffff, 16'h0001, 16'haaaa, 16'h5555, 16'h8000, 16'h7fff}, 1'b0}, 1'b1,
        '{'{21'h1fffff, 21'h000001, 21'h1faaaa, 21'h005555, 21'h1f8000, 21'h007fff},
          1'b0, 1'b0}},
      // start of calibration: this transaction is index zero and busy
      '{'{'{16'h1234, 16'hedcc, 16'h4000, 16'h0000, 16'hffff, 16'h8001}, 1'b1}, 1'b1,
        '{'{21'h001234, 21'h1fedcc, 21'h004000, 21'h000000, 21'h1fffff, 21'h1f8001},
          1'b1, 1'b0}},
      '{'{'{16'h0100, 16'hff00, 16'h4000, 16'h0010, 16'hfff0, 16'h0000}, 1'b0}, 1'b1,
        '{'{21'h000100, 21'h1fff00, 21'h004000, 21'h000010, 21'h1ffff0, 21'h000000},
          1'b1, 1'b0}},
      // restart while collecting
      '{'{'{16'h8000, 16'h7fff, 16'hc000, 16'h3fff, 16'h0002, 16'hfffe}, 1'b1}, 1'b1,
        '{'{21'h1f8000, 21'h007fff, 21'h1fc000, 21'h003fff, 21'h000002, 21'h1ffffe},
          1'b1, 1'b0}},
      '{'{'{16'h2a5c, 16'hd1e7, 16'h0bad, 16'hf00d, 16'h6c3a, 16'h9e21}, 1'b0}, 1'b0, '0},
      '{'{'{16'h7ffe, 16'h8001, 16'h4321, 16'hbcde, 16'h0f0f, 16'hf0f0}, 1'b0}, 1'b0, '0}
    };

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    smp.valid <= 1'b0;
    smp.acc_x <= '0;
    smp.acc_y <= '0;
    smp.acc_z <= '0;
    smp.rate_x <= '0;
    smp.rate_y <= '0;
    smp.rate_z <= '0;
    smp.start_cal <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++)
      put_sample(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);

    // widest ranges, extreme and random offsets, then noise with broken runs
    settle();
    cfg_write(imubc_pkg::REG_ACCEL_RANGE, 16'd3);
    cfg_write(imubc_pkg::REG_GYRO_RANGE, 16'd3);
    cfg_write(imubc_pkg::REG_ACCEL_OFFSET_X, 16'h8000);
    cfg_write(imubc_pkg::REG_ACCEL_OFFSET_Y, 16'h7fff);
    cfg_write(imubc_pkg::REG_ACCEL_OFFSET_Z, 16'($urandom));
    cfg_write(imubc_pkg::REG_GYRO_OFFSET_X, 16'($urandom));
    cfg_write(imubc_pkg::REG_GYRO_OFFSET_Y, 16'h8000);
    cfg_write(imubc_pkg::REG_GYRO_OFFSET_Z, 16'h7fff);
    cfg_we <= 1'b0;
    run_noise(40, 1'b1);

    // mid ranges, random offsets, then one full calibration of a still sensor
    settle();
    cfg_write(imubc_pkg::REG_ACCEL_RANGE, 16'($urandom_range(1, 2)));
    cfg_write(imubc_pkg::REG_GYRO_RANGE, 16'($urandom_range(1, 2)));
    cfg_write(imubc_pkg::REG_ACCEL_OFFSET_X, 16'($urandom));
    cfg_write(imubc_pkg::REG_ACCEL_OFFSET_Y, 16'($urandom));
    cfg_write(imubc_pkg::REG_ACCEL_OFFSET_Z, 16'($urandom));
    cfg_write(imubc_pkg::REG_GYRO_OFFSET_X, 16'($urandom));
    cfg_write(imubc_pkg::REG_GYRO_OFFSET_Y, 16'($urandom));
    cfg_write(imubc_pkg::REG_GYRO_OFFSET_Z, 16'($urandom));
    cfg_we <= 1'b0;
    for (int k = 0; k < NAXES; k++)
      run_centre[k] = int'($urandom_range(0, 40000)) - 20000;
    run_spread = $urandom_range(50, 2000);
    // one early restart, then the run goes to completion and a little beyond
    restart_at = $urandom_range(20, 120);
    n_run = restart_at + SKIP_N + AVG_N + 30;
    for (int i = 0; i < n_run; i++)
      put_sample(near_sample(i == 0 || i == restart_at), 1'b0, '0);

    // range change after calibration: the learned z bias keeps its old one g
    settle();
    cfg_write(imubc_pkg::REG_ACCEL_RANGE, 16'd0);
    cfg_write(imubc_pkg::REG_GYRO_RANGE, 16'd0);
    cfg_we <= 1'b0;
    run_noise(30, 1'b0);

    // offset writes drop the learned biases
    settle();
    cfg_write(imubc_pkg::REG_ACCEL_RANGE, 16'd3);
    cfg_write(imubc_pkg::REG_GYRO_OFFSET_Z, 16'h0000);
    cfg_write(imubc_pkg::REG_ACCEL_OFFSET_X, 16'h7fff);
    cfg_we <= 1'b0;
    run_noise(30, 1'b0);

    settle();
    if (pending_results.size() != 0) begin
      $error("%0d result transactions never arrived", pending_results.size());
      n_err++;
    end
    if (n_err == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/imubc_pkg.sv
rtl/imubc_if.sv
rtl/imubc_div.sv
rtl/imu_bias_calibrate_and_scale_core.sv
sim/tb.sv
